// ===== hdl/mfd_pkg.sv =====
// Shared types, constants and the debounce step for the motor fault debounce monitor.
`default_nettype none

package mfd_pkg;

  // Motor modes as carried on the tick channel
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_START  = 2'd1,
    MODE_CLOSED = 2'd2,
    MODE_STOP   = 2'd3
  } mode_t;

  // Configuration register indexes; index 3 addresses nothing
  localparam int unsigned CFG_INDEX_BITS = 2;
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LOW_SPEED_CURRENT_LIMIT = 2'd0,
    REG_OVER_VOLTAGE_LIMIT      = 2'd1,
    REG_SPEED_SCALE_MAX         = 2'd2
  } cfg_index_t;

  // Register values after reset, before truncation to the configured widths
  localparam int unsigned LOW_SPEED_CURRENT_LIMIT_RESET = 2048;
  localparam int unsigned OVER_VOLTAGE_LIMIT_RESET      = 4095;
  localparam int unsigned SPEED_SCALE_MAX_RESET         = 65535;

  // Thresholds and margins
  localparam int unsigned LOW_SPEED_SCALE         = 200;
  localparam int unsigned LOW_SPEED_OC_LIMIT      = 20;
  localparam int unsigned OVERVOLTAGE_LIMIT_TICKS = 15;
  localparam int unsigned OVERSHOOT_GAP           = 200;
  localparam int unsigned OVERSHOOT_LIMIT_TICKS   = 5;
  localparam int unsigned RUNAWAY_LIMIT_TICKS     = 10;
  localparam int unsigned RUNAWAY_MARGIN          = 100;
  localparam int unsigned START_STALL_TICKS       = 60;
  localparam int unsigned START_OC_LIMIT          = 20;

  // Field and counter widths
  localparam int unsigned TICKS_BITS     = 8;
  localparam int unsigned CNT_BITS       = 5;
  localparam int unsigned LS_OC_CNT_BITS = 5;
  localparam int unsigned OV_CNT_BITS    = 5;
  localparam int unsigned OS_CNT_BITS    = 3;
  localparam int unsigned RA_CNT_BITS    = 4;
  localparam int unsigned ST_OC_CNT_BITS = 5;

  typedef struct packed {
    logic [CNT_BITS-1:0] count;
    logic                fire;
  } deb_t;

  // Debounce step: count while cond holds, else clear; fire and clear past the limit
  function automatic deb_t debounce(input logic [CNT_BITS-1:0] cnt, input logic cond,
                                    input logic [CNT_BITS-1:0] limit);
    deb_t                r;
    logic [CNT_BITS-1:0] inc;
    inc     = cnt + 1'b1;
    r.count = '0;
    r.fire  = 1'b0;
    if (cond) begin
      if (inc > limit) begin
        r.fire = 1'b1;
      end else begin
        r.count = inc;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mfd_tick_if.sv =====
// Tick channel: one monitor sample beat with valid/ready.
`default_nettype none

interface mfd_tick_if #(
  parameter int unsigned ADC_BITS   = 12,
  parameter int unsigned SPEED_BITS = 16
) ();
  import mfd_pkg::*;

  logic                  valid;
  logic                  ready;
  mode_t                 mode;
  logic [ADC_BITS-1:0]   current_sample;
  logic [ADC_BITS-1:0]   volt_high_sample;
  logic [ADC_BITS-1:0]   volt_low_sample;
  logic [SPEED_BITS-1:0] ramp_speed;
  logic [SPEED_BITS-1:0] target_speed;
  logic [TICKS_BITS-1:0] start_ticks;

  modport source (
    output valid, mode, current_sample, volt_high_sample, volt_low_sample,
           ramp_speed, target_speed, start_ticks,
    input  ready
  );

  modport sink (
    input  valid, mode, current_sample, volt_high_sample, volt_low_sample,
           ramp_speed, target_speed, start_ticks,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/mfd_fault_if.sv =====
// Fault channel: one beat of three fault flags per tick, with valid/ready.
`default_nettype none

interface mfd_fault_if ();
  logic valid;
  logic ready;
  logic fault_overcurrent;
  logic fault_overvoltage;
  logic fault_overspeed;

  modport source (
    output valid, fault_overcurrent, fault_overvoltage, fault_overspeed,
    input  ready
  );

  modport sink (
    input  valid, fault_overcurrent, fault_overvoltage, fault_overspeed,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/mfd_cfg_if.sv =====
// Configuration write channel: register index and data, with valid/ready.
`default_nettype none

interface mfd_cfg_if #(
  parameter int unsigned DATA_BITS = 16
) ();
  import mfd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [DATA_BITS-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/motor_fault_debounce_monitor.sv =====
// Motor fault debounce monitor: five debounce counters raising three fault flags per tick.
//
// Use: each beat on the tick channel is one monitor sample (mode, current, the two
// terminal voltages, ramp and target speed, start timer). For every tick beat one
// beat leaves on the fault channel with the over-current, over-voltage and
// over-speed flags for that tick, in order.
// Configuration: the cfg channel writes index 0 (low-speed current limit),
// 1 (over-voltage limit) or 2 (maximum speed scale); other indexes are dropped.
// It is always ready; write only while no tick is in flight.
// Path: an accepted tick is held in the input register, then moves to the fault
// register, which drives the fault beat; the compares and counter updates sit between.
// Throughput: one tick per cycle unless the fault beat stalls; one debounce pass per tick.
// Reset (rst, synchronous): counters clear, registers take their reset limits,
// both stages empty.
// Stall: while the fault beat waits, one more tick is held in the input register;
// the tick channel then drops ready until the fault beat is taken.
`default_nettype none

module motor_fault_debounce_monitor #(
  parameter int unsigned ADC_BITS   = 12,
  parameter int unsigned SPEED_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  mfd_tick_if.sink          tick,
  mfd_cfg_if.sink           cfg,
  mfd_fault_if.source       fault
);
  import mfd_pkg::*;

  localparam int unsigned SUM_BITS = SPEED_BITS + 1;

  // Configuration registers
  logic [ADC_BITS-1:0]   low_speed_current_limit;
  logic [ADC_BITS-1:0]   over_voltage_limit;
  logic [SPEED_BITS-1:0] speed_scale_max;

  // Input register stage
  logic                  s1_valid;
  mode_t                 s1_mode;
  logic [ADC_BITS-1:0]   s1_current;
  logic [ADC_BITS-1:0]   s1_volt_high;
  logic [ADC_BITS-1:0]   s1_volt_low;
  logic [SPEED_BITS-1:0] s1_ramp;
  logic [SPEED_BITS-1:0] s1_target;
  logic [TICKS_BITS-1:0] s1_ticks;

  // Debounce counters
  logic [LS_OC_CNT_BITS-1:0] low_speed_oc_count, low_speed_oc_count_next;
  logic [OV_CNT_BITS-1:0]    overvoltage_count, overvoltage_count_next;
  logic [OS_CNT_BITS-1:0]    overshoot_count, overshoot_count_next;
  logic [RA_CNT_BITS-1:0]    runaway_count, runaway_count_next;
  logic [ST_OC_CNT_BITS-1:0] start_oc_count, start_oc_count_next;

  logic out_free;
  logic s1_adv;

  logic                fault_oc_next;
  logic                fault_ov_next;
  logic                fault_os_next;
  logic [ADC_BITS-1:0] volt_diff;
  logic                current_over;
  logic                volt_over;
  logic                runaway_cond;
  logic                overshoot_cond;
  logic                in_start;
  logic                in_closed;
  logic                in_stop;
  deb_t                deb_start_oc;
  deb_t                deb_low_oc;
  deb_t                deb_ov;
  deb_t                deb_runaway;
  deb_t                deb_overshoot;

  // Handshake between the two stages
  assign out_free   = !fault.valid || fault.ready;
  assign s1_adv     = s1_valid && out_free;
  assign tick.ready = !s1_valid || out_free;
  assign cfg.ready  = 1'b1;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      low_speed_current_limit <= ADC_BITS'(LOW_SPEED_CURRENT_LIMIT_RESET);
      over_voltage_limit      <= ADC_BITS'(OVER_VOLTAGE_LIMIT_RESET);
      speed_scale_max         <= SPEED_BITS'(SPEED_SCALE_MAX_RESET);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_LOW_SPEED_CURRENT_LIMIT: low_speed_current_limit <= cfg.data[ADC_BITS-1:0];
        REG_OVER_VOLTAGE_LIMIT:      over_voltage_limit      <= cfg.data[ADC_BITS-1:0];
        REG_SPEED_SCALE_MAX:         speed_scale_max         <= cfg.data[SPEED_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Capture the tick beat
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_mode      <= tick.mode;
      s1_current   <= tick.current_sample;
      s1_volt_high <= tick.volt_high_sample;
      s1_volt_low  <= tick.volt_low_sample;
      s1_ramp      <= tick.ramp_speed;
      s1_target    <= tick.target_speed;
      s1_ticks     <= tick.start_ticks;
    end
  end

  // Fault conditions for the held tick
  always_comb begin
    in_start       = (s1_mode == MODE_START);
    in_closed      = (s1_mode == MODE_CLOSED);
    in_stop        = (s1_mode == MODE_STOP);
    volt_diff      = (s1_volt_high > s1_volt_low) ? (s1_volt_high - s1_volt_low) : '0;
    current_over   = (s1_current > low_speed_current_limit);
    volt_over      = (volt_diff >= over_voltage_limit);
    runaway_cond   = ({1'b0, s1_ramp} >
                      ({1'b0, speed_scale_max} + SUM_BITS'(RUNAWAY_MARGIN)));
    overshoot_cond = (s1_target != '0) &&
                     ({1'b0, s1_ramp} >= ({1'b0, s1_target} + SUM_BITS'(OVERSHOOT_GAP)));
  end

  // Debounce steps
  always_comb begin
    deb_start_oc  = debounce(CNT_BITS'(start_oc_count), current_over,
                             CNT_BITS'(START_OC_LIMIT));
    deb_low_oc    = debounce(CNT_BITS'(low_speed_oc_count), current_over,
                             CNT_BITS'(LOW_SPEED_OC_LIMIT));
    deb_ov        = debounce(CNT_BITS'(overvoltage_count), volt_over,
                             CNT_BITS'(OVERVOLTAGE_LIMIT_TICKS));
    deb_runaway   = debounce(CNT_BITS'(runaway_count), runaway_cond,
                             CNT_BITS'(RUNAWAY_LIMIT_TICKS));
    deb_overshoot = debounce(CNT_BITS'(overshoot_count), overshoot_cond,
                             CNT_BITS'(OVERSHOOT_LIMIT_TICKS));
  end

  // Gate counters and flags by mode; skipped checks hold their counters
  always_comb begin
    start_oc_count_next     = start_oc_count;
    low_speed_oc_count_next = low_speed_oc_count;
    overvoltage_count_next  = overvoltage_count;
    runaway_count_next      = runaway_count;
    overshoot_count_next    = overshoot_count;
    fault_oc_next           = 1'b0;
    fault_ov_next           = 1'b0;
    fault_os_next           = 1'b0;
    if (in_start) begin
      start_oc_count_next = deb_start_oc.count[ST_OC_CNT_BITS-1:0];
      fault_oc_next       = deb_start_oc.fire ||
                            (s1_ticks > TICKS_BITS'(START_STALL_TICKS));
    end
    if (in_closed || in_stop) begin
      if (s1_ramp <= SPEED_BITS'(LOW_SPEED_SCALE)) begin
        low_speed_oc_count_next = deb_low_oc.count[LS_OC_CNT_BITS-1:0];
        fault_oc_next           = fault_oc_next || deb_low_oc.fire;
      end
      overvoltage_count_next = deb_ov.count[OV_CNT_BITS-1:0];
      fault_ov_next          = deb_ov.fire;
    end
    if (in_closed || in_start) begin
      runaway_count_next = deb_runaway.count[RA_CNT_BITS-1:0];
      fault_os_next      = deb_runaway.fire;
    end
    if (in_closed) begin
      overshoot_count_next = deb_overshoot.count[OS_CNT_BITS-1:0];
      fault_os_next        = fault_os_next || deb_overshoot.fire;
    end
  end

  // Advance counters as the tick leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_oc_count     <= '0;
      low_speed_oc_count <= '0;
      overvoltage_count  <= '0;
      runaway_count      <= '0;
      overshoot_count    <= '0;
    end else if (s1_adv) begin
      start_oc_count     <= start_oc_count_next;
      low_speed_oc_count <= low_speed_oc_count_next;
      overvoltage_count  <= overvoltage_count_next;
      runaway_count      <= runaway_count_next;
      overshoot_count    <= overshoot_count_next;
    end
  end

  // Fault register
  always_ff @(posedge clk) begin
    if (rst) begin
      fault.valid <= 1'b0;
    end else if (out_free) begin
      fault.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      fault.fault_overcurrent <= fault_oc_next;
      fault.fault_overvoltage <= fault_ov_next;
      fault.fault_overspeed   <= fault_os_next;
    end
  end

  // Counters never pass their limits
  a_count_bounds: assert property (@(posedge clk) disable iff (rst)
    (start_oc_count <= ST_OC_CNT_BITS'(START_OC_LIMIT)) &&
    (low_speed_oc_count <= LS_OC_CNT_BITS'(LOW_SPEED_OC_LIMIT)) &&
    (overvoltage_count <= OV_CNT_BITS'(OVERVOLTAGE_LIMIT_TICKS)) &&
    (runaway_count <= RA_CNT_BITS'(RUNAWAY_LIMIT_TICKS)) &&
    (overshoot_count <= OS_CNT_BITS'(OVERSHOOT_LIMIT_TICKS)))
    else $error("debounce counter beyond its limit");

  // An idle tick leaves every counter as it was
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    s1_adv && (s1_mode == MODE_IDLE) |=>
      $stable(start_oc_count) && $stable(low_speed_oc_count) &&
      $stable(overvoltage_count) && $stable(runaway_count) && $stable(overshoot_count))
    else $error("counter moved on an idle tick");

  // A start stall raises over-current on the very beat it leaves
  a_stall_fires: assert property (@(posedge clk) disable iff (rst)
    s1_adv && (s1_mode == MODE_START) && (s1_ticks > TICKS_BITS'(START_STALL_TICKS)) |=>
      fault.valid && fault.fault_overcurrent)
    else $error("start stall did not raise over-current");

  // Stop mode never flags over-speed
  a_stop_no_speed: assert property (@(posedge clk) disable iff (rst)
    s1_adv && (s1_mode == MODE_STOP) |=> !fault.fault_overspeed)
    else $error("over-speed flagged in stop mode");

endmodule

`default_nettype wire

// ===== test/mfd_flag_compare.sv =====
// Fault flag comparator: watches the monitor channels, predicts each fault beat and compares it.
`timescale 1ns / 1ps

module mfd_flag_compare #(
  parameter int unsigned ADC_BITS   = 12,
  parameter int unsigned SPEED_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  mfd_tick_if         tick,
  mfd_cfg_if          cfg,
  mfd_fault_if        fault,
  output int unsigned errors,
  output int unsigned outstanding
);
  import mfd_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic oc;
    logic ov;
    logic os;
  } fault_flags_t;

  fault_flags_t expected_flags[$];
  int unsigned  mismatches;

  // Local copy of the limit registers
  logic [ADC_BITS-1:0]   cur_cap;
  logic [ADC_BITS-1:0]   volt_cap;
  logic [SPEED_BITS-1:0] speed_cap;

  // Local copy of the debounce counters
  logic [LS_OC_CNT_BITS-1:0] low_oc_run;
  logic [OV_CNT_BITS-1:0]    volt_run;
  logic [OS_CNT_BITS-1:0]    overshoot_run;
  logic [RA_CNT_BITS-1:0]    runaway_run;
  logic [ST_OC_CNT_BITS-1:0] start_oc_run;

  assign errors = mismatches;

  // Advance a run of consecutive hits; report a fire and restart once past the limit
  function automatic bit advance_run(input int unsigned run, input bit hit,
                                     input int unsigned lim, output int unsigned run_next);
    run_next = 0;
    if (!hit) return 1'b0;
    if (run + 1 > lim) return 1'b1;
    run_next = run + 1;
    return 1'b0;
  endfunction

  // Work out the flags for the tick on the channel and queue them
  task automatic predict_tick();
    fault_flags_t          f;
    int unsigned           nxt;
    logic [ADC_BITS-1:0]   diff;
    logic [ADC_BITS-1:0]   cur;
    logic [SPEED_BITS-1:0] ramp;
    logic [SPEED_BITS-1:0] target;
    f      = '0;
    cur    = tick.current_sample;
    ramp   = tick.ramp_speed;
    target = tick.target_speed;
    diff   = (tick.volt_high_sample > tick.volt_low_sample) ?
             tick.volt_high_sample - tick.volt_low_sample : '0;
    if (tick.mode == MODE_START) begin
      f.oc = advance_run(start_oc_run, cur > cur_cap, START_OC_LIMIT, nxt);
      start_oc_run = ST_OC_CNT_BITS'(nxt);
      if (tick.start_ticks > START_STALL_TICKS) f.oc = 1'b1;
    end
    if (tick.mode == MODE_CLOSED || tick.mode == MODE_STOP) begin
      // low-speed counter holds above the low-speed scale
      if (ramp <= LOW_SPEED_SCALE) begin
        f.oc = f.oc | advance_run(low_oc_run, cur > cur_cap, LOW_SPEED_OC_LIMIT, nxt);
        low_oc_run = LS_OC_CNT_BITS'(nxt);
      end
      f.ov = advance_run(volt_run, diff >= volt_cap, OVERVOLTAGE_LIMIT_TICKS, nxt);
      volt_run = OV_CNT_BITS'(nxt);
    end
    if (tick.mode == MODE_CLOSED || tick.mode == MODE_START) begin
      f.os = advance_run(runaway_run, ramp > speed_cap + RUNAWAY_MARGIN,
                         RUNAWAY_LIMIT_TICKS, nxt);
      runaway_run = RA_CNT_BITS'(nxt);
    end
    if (tick.mode == MODE_CLOSED) begin
      f.os = f.os | advance_run(overshoot_run,
                                target != 0 && ramp >= target + OVERSHOOT_GAP,
                                OVERSHOOT_LIMIT_TICKS, nxt);
      overshoot_run = OS_CNT_BITS'(nxt);
    end
    expected_flags.push_back(f);
  endtask

  // Compare one fault beat with the oldest expectation
  task automatic compare_beat();
    fault_flags_t want;
    fault_flags_t got;
    got = '{oc: fault.fault_overcurrent, ov: fault.fault_overvoltage,
            os: fault.fault_overspeed};
    if (expected_flags.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: fault beat with nothing expected: oc %b ov %b os %b",
                 $realtime, got.oc, got.ov, got.os);
    end else begin
      want = expected_flags.pop_front();
      if (got.oc !== want.oc || got.ov !== want.ov || got.os !== want.os) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: fault beat: expected oc %b ov %b os %b, got oc %b ov %b os %b",
                   $realtime, want.oc, want.ov, want.os, got.oc, got.ov, got.os);
      end
    end
  endtask

  // Track register writes, predict accepted ticks and check fault beats
  always @(posedge clk) begin
    if (rst) begin
      cur_cap       = ADC_BITS'(LOW_SPEED_CURRENT_LIMIT_RESET);
      volt_cap      = ADC_BITS'(OVER_VOLTAGE_LIMIT_RESET);
      speed_cap     = SPEED_BITS'(SPEED_SCALE_MAX_RESET);
      low_oc_run    = '0;
      volt_run      = '0;
      overshoot_run = '0;
      runaway_run   = '0;
      start_oc_run  = '0;
      expected_flags.delete();
    end else begin
      if (fault.valid && fault.ready) compare_beat();
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_LOW_SPEED_CURRENT_LIMIT: cur_cap   = cfg.data[ADC_BITS-1:0];
          REG_OVER_VOLTAGE_LIMIT:      volt_cap  = cfg.data[ADC_BITS-1:0];
          REG_SPEED_SCALE_MAX:         speed_cap = cfg.data[SPEED_BITS-1:0];
          default: ;
        endcase
      end
      if (tick.valid && tick.ready) predict_tick();
    end
    outstanding <= expected_flags.size();
  end

  initial mismatches = 0;

endmodule

// ===== test/tb_top.sv =====
// Testbench top: reset, limit writes, directed and random monitor ticks, and the verdict.
`timescale 1ns / 1ps

module tb_top;
  import mfd_pkg::*;

  localparam int unsigned ADC_BITS    = 12;
  localparam int unsigned SPEED_BITS  = 16;
  localparam int unsigned ADC_MAX     = (1 << ADC_BITS) - 1;
  localparam int unsigned SPEED_MAX   = (1 << SPEED_BITS) - 1;
  localparam int unsigned TICKS_MAX   = (1 << TICKS_BITS) - 1;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_TICKS = 190;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned STUCK_LIMIT = 3000;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    mode_t                 mode;
    logic [ADC_BITS-1:0]   cur;
    logic [ADC_BITS-1:0]   vhi;
    logic [ADC_BITS-1:0]   vlo;
    logic [SPEED_BITS-1:0] ramp;
    logic [SPEED_BITS-1:0] target;
    logic [TICKS_BITS-1:0] ticks;
  } tick_t;

  logic clk = 1'b0;
  logic rst;
  bit   calm     = 1'b0;
  bit   hold_req = 1'b0;

  // Limits last written, used only to steer the stimulus
  logic [ADC_BITS-1:0]   cur_cap;
  logic [ADC_BITS-1:0]   volt_cap;
  logic [SPEED_BITS-1:0] speed_cap;

  int unsigned stuck_cycles = 0;
  int unsigned mismatches;
  int unsigned pending_flags;

  mfd_tick_if  tick_ch ();
  mfd_cfg_if   cfg_ch ();
  mfd_fault_if fault_ch ();

  motor_fault_debounce_monitor dut (
    .clk   (clk),
    .rst   (rst),
    .tick  (tick_ch),
    .cfg   (cfg_ch),
    .fault (fault_ch)
  );

  mfd_flag_compare flag_cmp (
    .clk         (clk),
    .rst         (rst),
    .tick        (tick_ch),
    .cfg         (cfg_ch),
    .fault       (fault_ch),
    .errors      (mismatches),
    .outstanding (pending_flags)
  );

  always #4 clk = ~clk;

  // Abort when no channel has moved a beat for too long
  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (fault_ch.valid && fault_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("motor_fault_debounce_monitor: mismatch");
      $finish;
    end
  end

  // Fault sink: random stalls, one long hold-off on request, none in the calm phase
  initial begin
    fault_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        fault_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(5, 0) == 0) begin
        fault_ch.ready <= 1'b0;
        repeat ($urandom_range(14, 1)) @(posedge clk);
      end else begin
        fault_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic tick_t make_tick(input mode_t m, input int unsigned cur,
                                      input int unsigned vhi, input int unsigned vlo,
                                      input int unsigned ramp, input int unsigned target,
                                      input int unsigned ticks);
    tick_t t;
    t.mode   = m;
    t.cur    = ADC_BITS'(cur);
    t.vhi    = ADC_BITS'(vhi);
    t.vlo    = ADC_BITS'(vlo);
    t.ramp   = SPEED_BITS'(ramp);
    t.target = SPEED_BITS'(target);
    t.ticks  = TICKS_BITS'(ticks);
    return t;
  endfunction

  // Build a tick that keeps the conditions of one focus true when hot
  function automatic tick_t shape_tick(input mode_t m, input int unsigned focus,
                                       input bit hot);
    tick_t       t;
    int unsigned span;
    int unsigned lo;
    t = make_tick(m, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    // current above the cap when hot, at or below it otherwise
    if (hot && cur_cap < ADC_MAX) t.cur = ADC_BITS'($urandom_range(ADC_MAX, cur_cap + 1));
    else if (!hot) t.cur = ADC_BITS'($urandom_range(cur_cap, 0));
    // voltage difference at or past the limit when hot, often reversed when cold
    if (hot) begin
      span  = ADC_MAX - volt_cap;
      lo    = $urandom_range(span, 0);
      t.vlo = ADC_BITS'(lo);
      t.vhi = ADC_BITS'(lo + volt_cap + $urandom_range(span - lo, 0));
    end else if ($urandom_range(1, 0) == 1) begin
      t.vlo = ADC_BITS'($urandom_range(ADC_MAX, t.vhi));
    end
    if (focus == 0) begin
      t.ramp = hot ? SPEED_BITS'($urandom_range(LOW_SPEED_SCALE, 0)) :
                     SPEED_BITS'($urandom_range(LOW_SPEED_SCALE + 40, 0));
    end else if (focus == 1) begin
      // runaway above the speed cap, overshoot above the target
      if (hot && speed_cap + RUNAWAY_MARGIN < SPEED_MAX)
        t.ramp = SPEED_BITS'($urandom_range(SPEED_MAX, speed_cap + RUNAWAY_MARGIN + 1));
      else if (hot)
        t.ramp = SPEED_BITS'($urandom_range(SPEED_MAX, SPEED_MAX - 4000));
      if (hot && t.ramp > OVERSHOOT_GAP)
        t.target = SPEED_BITS'($urandom_range(t.ramp - OVERSHOOT_GAP, 1));
      else if ($urandom_range(3, 0) == 0)
        t.target = '0;
    end
    // keep the start timer mostly inside the stall window
    if ($urandom_range(5, 0) != 0) t.ticks = TICKS_BITS'($urandom_range(START_STALL_TICKS, 0));
    return t;
  endfunction

  // Offer one tick beat, after a random gap unless calm, and hold it until taken
  task automatic send_tick(input tick_t t);
    if (!calm && $urandom_range(5, 0) == 0) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(posedge clk);
    end
    tick_ch.valid            <= 1'b1;
    tick_ch.mode             <= t.mode;
    tick_ch.current_sample   <= t.cur;
    tick_ch.volt_high_sample <= t.vhi;
    tick_ch.volt_low_sample  <= t.vlo;
    tick_ch.ramp_speed       <= t.ramp;
    tick_ch.target_speed     <= t.target;
    tick_ch.start_ticks      <= t.ticks;
    do @(posedge clk); while (!tick_ch.ready);
  endtask

  task automatic write_beat(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Write all three limits, optionally poking the unused index as well
  task automatic load_limits(input logic [15:0] cur_data, input logic [15:0] volt_data,
                             input logic [15:0] speed_data, input bit spare);
    write_beat(REG_LOW_SPEED_CURRENT_LIMIT, cur_data);
    write_beat(REG_OVER_VOLTAGE_LIMIT, volt_data);
    if (spare) write_beat(REG_SPARE, 16'($urandom));
    write_beat(REG_SPEED_SCALE_MAX, speed_data);
    cfg_ch.valid <= 1'b0;
    cur_cap   = cur_data[ADC_BITS-1:0];
    volt_cap  = volt_data[ADC_BITS-1:0];
    speed_cap = speed_data[SPEED_BITS-1:0];
  endtask

  // Drop valid and wait until every expected fault beat has come back
  task automatic wait_quiet();
    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_flags != 0);
    repeat (4) @(posedge clk);
  endtask

  // Random episodes: one mode and focus held over a run, with noise mixed in
  task automatic run_phase(input int unsigned count);
    mode_t       m;
    int unsigned focus;
    int unsigned left;
    int unsigned heat;
    int unsigned sent;
    tick_t       t;
    sent = 0;
    while (sent < count) begin
      m     = mode_t'($urandom_range(MODE_STOP, MODE_START));
      focus = $urandom_range(2, 0);
      left  = $urandom_range(45, 1);
      heat  = ($urandom_range(3, 0) != 0) ? 97 : 60;
      while (left != 0 && sent < count) begin
        if ($urandom_range(99, 0) < 4)
          t = make_tick(mode_t'($urandom_range(MODE_STOP, MODE_IDLE)), $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom);
        else if ($urandom_range(99, 0) < 4)
          t = shape_tick(mode_t'($urandom_range(MODE_STOP, MODE_IDLE)), focus,
                         $urandom_range(99, 0) < heat);
        else
          t = shape_tick(m, focus, $urandom_range(99, 0) < heat);
        send_tick(t);
        left--;
        sent++;
      end
    end
  endtask

  initial begin
    rst                      <= 1'b1;
    tick_ch.valid            <= 1'b0;
    tick_ch.mode             <= MODE_IDLE;
    tick_ch.current_sample   <= '0;
    tick_ch.volt_high_sample <= '0;
    tick_ch.volt_low_sample  <= '0;
    tick_ch.ramp_speed       <= '0;
    tick_ch.target_speed     <= '0;
    tick_ch.start_ticks      <= '0;
    cfg_ch.valid             <= 1'b0;
    cfg_ch.index             <= REG_LOW_SPEED_CURRENT_LIMIT;
    cfg_ch.data              <= '0;
    cur_cap   = ADC_BITS'(LOW_SPEED_CURRENT_LIMIT_RESET);
    volt_cap  = ADC_BITS'(OVER_VOLTAGE_LIMIT_RESET);
    speed_cap = SPEED_BITS'(SPEED_SCALE_MAX_RESET);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks at the reset limits: field extremes, every mode, boundaries
    send_tick(make_tick(MODE_IDLE, 0, 0, 0, 0, 0, 0));
    send_tick(make_tick(MODE_IDLE, ADC_MAX, ADC_MAX, ADC_MAX, SPEED_MAX, SPEED_MAX, TICKS_MAX));
    send_tick(make_tick(MODE_START, ADC_MAX, 0, 0, SPEED_MAX, 0, START_STALL_TICKS));
    send_tick(make_tick(MODE_START, ADC_MAX, 0, 0, 0, 0, START_STALL_TICKS + 1));
    send_tick(make_tick(MODE_START, 0, ADC_MAX, 0, SPEED_MAX, SPEED_MAX, TICKS_MAX));
    send_tick(make_tick(MODE_CLOSED, 0, ADC_MAX, 0, SPEED_MAX,
                        SPEED_MAX - OVERSHOOT_GAP, 0));
    send_tick(make_tick(MODE_CLOSED, 0, ADC_MAX, 0, SPEED_MAX, SPEED_MAX, 0));
    send_tick(make_tick(MODE_CLOSED, 0, 0, 0, SPEED_MAX, 0, 0));
    send_tick(make_tick(MODE_STOP, ADC_MAX, 0, ADC_MAX, LOW_SPEED_SCALE, 0, 0));
    send_tick(make_tick(MODE_STOP, LOW_SPEED_CURRENT_LIMIT_RESET + 1, ADC_MAX, ADC_MAX,
                        LOW_SPEED_SCALE, 0, 0));
    send_tick(make_tick(MODE_STOP, ADC_MAX, ADC_MAX, 0, LOW_SPEED_SCALE + 1, 0, 0));
    send_tick(make_tick(MODE_CLOSED, LOW_SPEED_CURRENT_LIMIT_RESET, 1, 0, 0, 1, 0));
    send_tick(make_tick(MODE_IDLE, 0, ADC_MAX, 0, SPEED_MAX, 1, TICKS_MAX));
    send_tick(make_tick(MODE_CLOSED, ADC_MAX, ADC_MAX, 0, SPEED_MAX - 1,
                        SPEED_MAX - OVERSHOOT_GAP - 1, 0));
    wait_quiet();

    // Random phases, each under its own limits; hold the sink off early, go calm at the end
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       load_limits('0, '0, '0, 1'b1);
        1:       load_limits('1, '1, '1, 1'b0);
        default: load_limits(16'($urandom), {4'($urandom), 12'($urandom_range(1200, 0))},
                             16'($urandom_range(60000, 0)), 1'b0);
      endcase
      if (p == 0) hold_req = 1'b1;
      if (p == PHASES - 1) calm = 1'b1;
      run_phase(PHASE_TICKS);
      wait_quiet();
    end

    if (mismatches == 0) begin
      $display("motor_fault_debounce_monitor: match");
    end else begin
      $display("motor_fault_debounce_monitor: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mfd_pkg.sv
hdl/mfd_tick_if.sv
hdl/mfd_fault_if.sv
hdl/mfd_cfg_if.sv
hdl/motor_fault_debounce_monitor.sv
test/mfd_flag_compare.sv
test/tb_top.sv
